### rtl/celu_pkg.sv
// Shared constants and elaboration-time table helpers for the CELU activation unit.
package celu_pkg;

  localparam int DataWidthDef       = 16;
  localparam int FracBitsDef        = 12;
  localparam int ExpTableEntriesDef = 64;

  localparam int CfgWidth      = 16;
  localparam int CfgIndexWidth = 2;
  localparam int TableFrac     = 30;
  localparam int DomainLog2    = 4;
  localparam int NodeWidth     = TableFrac + 1;

  localparam logic [CfgWidth-1:0] AlphaReset = 16'd4096;

  localparam logic [CfgIndexWidth-1:0] RegAlphaScale      = 2'd0;
  localparam logic [CfgIndexWidth-1:0] RegAlphaReciprocal = 2'd1;

  // exp(-h) in Q30 from a truncated Taylor series, h given in Q30.
  function automatic longint unsigned exp_step(input longint unsigned h);
    longint unsigned one;
    longint unsigned term;
    longint sum;
    one  = 64'd1 << TableFrac;
    term = one;
    sum  = longint'(one);
    term = ((term * h) >> TableFrac) / 64'd1;  sum = sum - longint'(term);
    term = ((term * h) >> TableFrac) / 64'd2;  sum = sum + longint'(term);
    term = ((term * h) >> TableFrac) / 64'd3;  sum = sum - longint'(term);
    term = ((term * h) >> TableFrac) / 64'd4;  sum = sum + longint'(term);
    term = ((term * h) >> TableFrac) / 64'd5;  sum = sum - longint'(term);
    term = ((term * h) >> TableFrac) / 64'd6;  sum = sum + longint'(term);
    term = ((term * h) >> TableFrac) / 64'd7;  sum = sum - longint'(term);
    term = ((term * h) >> TableFrac) / 64'd8;  sum = sum + longint'(term);
    term = ((term * h) >> TableFrac) / 64'd9;  sum = sum - longint'(term);
    term = ((term * h) >> TableFrac) / 64'd10; sum = sum + longint'(term);
    term = ((term * h) >> TableFrac) / 64'd11; sum = sum - longint'(term);
    term = ((term * h) >> TableFrac) / 64'd12; sum = sum + longint'(term);
    term = ((term * h) >> TableFrac) / 64'd13; sum = sum - longint'(term);
    term = ((term * h) >> TableFrac) / 64'd14; sum = sum + longint'(term);
    term = ((term * h) >> TableFrac) / 64'd15; sum = sum - longint'(term);
    term = ((term * h) >> TableFrac) / 64'd16; sum = sum + longint'(term);
    term = ((term * h) >> TableFrac) / 64'd17; sum = sum - longint'(term);
    term = ((term * h) >> TableFrac) / 64'd18; sum = sum + longint'(term);
    term = ((term * h) >> TableFrac) / 64'd19; sum = sum - longint'(term);
    term = ((term * h) >> TableFrac) / 64'd20; sum = sum + longint'(term);
    term = ((term * h) >> TableFrac) / 64'd21; sum = sum - longint'(term);
    term = ((term * h) >> TableFrac) / 64'd22; sum = sum + longint'(term);
    term = ((term * h) >> TableFrac) / 64'd23; sum = sum - longint'(term);
    term = ((term * h) >> TableFrac) / 64'd24; sum = sum + longint'(term);
    term = ((term * h) >> TableFrac) / 64'd25; sum = sum - longint'(term);
    return (sum < 0) ? 64'd0 : longint'(sum);
  endfunction

  // Node k of the table: 1 - exp(-h)^k in Q30, built by repeated truncated multiplies.
  function automatic logic [NodeWidth-1:0] exp_node(input int k, input longint unsigned step);
    longint unsigned one;
    longint unsigned e;
    one = 64'd1 << TableFrac;
    e   = one;
    for (int j = 0; j < k; j++) begin
      e = (e * step) >> TableFrac;
    end
    return NodeWidth'(one - ((e > one) ? one : e));
  endfunction

endpackage

### rtl/celu_expm1_interp.sv
// Two-stage piecewise-linear lookup of 1 - exp(-u) over the table domain.
module celu_expm1_interp #(
  parameter int FRAC_BITS         = celu_pkg::FracBitsDef,
  parameter int EXP_TABLE_ENTRIES = celu_pkg::ExpTableEntriesDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  logic [FRAC_BITS+celu_pkg::DomainLog2:0] u_i,
  output logic                             valid_o,
  output logic [celu_pkg::NodeWidth-1:0]   m_o
);

  localparam int NW     = celu_pkg::NodeWidth;
  localparam int RemW   = FRAC_BITS + celu_pkg::DomainLog2;
  localparam int UW     = RemW + 1;
  localparam int IdxW   = $clog2(EXP_TABLE_ENTRIES + 1);
  localparam int PW     = UW + IdxW;
  localparam longint unsigned StepH =
    (64'd1 << (celu_pkg::TableFrac + celu_pkg::DomainLog2)) / EXP_TABLE_ENTRIES;
  localparam longint unsigned ExpStep = celu_pkg::exp_step(StepH);

  logic [NW-1:0] node_tab [EXP_TABLE_ENTRIES+1];

  for (genvar k = 0; k <= EXP_TABLE_ENTRIES; k++) begin : g_node
    assign node_tab[k] = celu_pkg::exp_node(k, ExpStep);
  end

  logic [PW-1:0]     pos;
  logic [PW-RemW-1:0] idx_full;
  logic              at_end;
  logic [IdxW-1:0]   idx_sel;
  logic [NW-1:0]     lo, hi;

  logic            a_valid_q;
  logic [NW-1:0]   a_lo_q, a_lo_d;
  logic [NW-1:0]   a_d_q, a_d_d;
  logic [RemW-1:0] a_rem_q;

  logic [NW+RemW-1:0] interp_prod;
  logic [NW:0]        m_sum;

  logic          b_valid_q;
  logic [NW-1:0] b_m_q;

  always_comb begin
    pos      = PW'(u_i) * PW'(EXP_TABLE_ENTRIES);
    idx_full = pos[PW-1:RemW];
    at_end   = (idx_full >= (PW-RemW)'(EXP_TABLE_ENTRIES));
    idx_sel  = at_end ? IdxW'(EXP_TABLE_ENTRIES - 1) : idx_full[IdxW-1:0];
    lo       = node_tab[idx_sel];
    hi       = node_tab[idx_sel + IdxW'(1)];
    // Past the last segment the last node is used as is.
    if (at_end) begin
      a_lo_d = hi;
      a_d_d  = '0;
    end else begin
      a_lo_d = lo;
      a_d_d  = (hi > lo) ? (hi - lo) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_lo_q  <= a_lo_d;
    a_d_q   <= a_d_d;
    a_rem_q <= pos[RemW-1:0];
    b_m_q   <= m_sum[NW-1:0];
  end

  always_comb begin
    interp_prod = (NW+RemW)'(a_d_q) * (NW+RemW)'(a_rem_q);
    m_sum       = (NW+1)'(a_lo_q) + (NW+1)'(interp_prod >> RemW);
  end

  assign valid_o = b_valid_q;
  assign m_o     = b_m_q;

endmodule

### rtl/celu_activation_unit.sv
// Top level of the CELU activation unit: sign split, scaling, lookup and output saturation.
//
// The unit takes one sample in every clock cycle and never reports busy. Each request's result
// appears on activated_o after the register stages listed below, in order, with valid_o high
// for one cycle. The six register stages are the input capture, the reciprocal multiply,
// the table lookup, the interpolation multiply, the alpha multiply and the saturating
// output register. The result receiver has no way to hold results off, so it must take
// a result in every cycle that valid_o is high. Configuration writes are always ready
// and take effect on the next cycle; write them only while no request is in flight.
module celu_activation_unit #(
  parameter int DATA_WIDTH        = celu_pkg::DataWidthDef,
  parameter int FRAC_BITS         = celu_pkg::FracBitsDef,
  parameter int EXP_TABLE_ENTRIES = celu_pkg::ExpTableEntriesDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic signed [DATA_WIDTH-1:0]        sample_i,
  output logic                                valid_o,
  output logic signed [DATA_WIDTH-1:0]        activated_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [celu_pkg::CfgIndexWidth-1:0]  cfg_index_i,
  input  logic [celu_pkg::CfgWidth-1:0]       cfg_data_i
);

  localparam int W     = DATA_WIDTH;
  localparam int CW    = celu_pkg::CfgWidth;
  localparam int NW    = celu_pkg::NodeWidth;
  localparam int TQ    = celu_pkg::TableFrac;
  localparam int UW    = FRAC_BITS + celu_pkg::DomainLog2 + 1;
  localparam int ProdW = W + CW;
  localparam int SumW  = (ProdW + 1 > UW) ? ProdW + 1 : UW;
  localparam int MagW  = CW + NW + 1 - TQ;
  localparam int CmpW  = (MagW > W) ? MagW : W;

  // Configuration registers.
  logic [CW-1:0] alpha_scale_q, alpha_recip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_scale_q <= celu_pkg::AlphaReset;
      alpha_recip_q <= celu_pkg::AlphaReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        celu_pkg::RegAlphaScale:      alpha_scale_q <= cfg_data_i;
        celu_pkg::RegAlphaReciprocal: alpha_recip_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  // Stage 1: capture and magnitude. Zero goes down the negative path and yields zero.
  logic         s1_valid_q;
  logic         s1_pos_q;
  logic [W-1:0] s1_x_q, s1_ax_q;

  // Stage 2: u = round(|x| / alpha), clamped to the end of the table domain.
  logic [ProdW-1:0] recip_prod;
  logic [SumW-1:0]  u_round, u_clamp;
  logic             s2_valid_q;
  logic             s2_pos_q;
  logic [W-1:0]     s2_x_q;
  logic [UW-1:0]    s2_u_q;

  // Sideband that rides alongside the two lookup stages.
  logic         s3_pos_q, s4_pos_q;
  logic [W-1:0] s3_x_q, s4_x_q;
  logic         lut_valid;
  logic [NW-1:0] lut_m;

  // Stage 5: magnitude = round(alpha * m).
  logic [CW+NW:0] alpha_prod;
  logic           s5_valid_q;
  logic           s5_pos_q;
  logic [W-1:0]   s5_x_q;
  logic [MagW-1:0] s5_mag_q;

  // Stage 6: saturation and output.
  logic [CmpW-1:0] mag_ext, mag_sat;
  logic [W-1:0]    neg_res;
  logic            out_valid_q;
  logic [W-1:0]    out_data_q, out_data_d;

  always_comb begin
    recip_prod = ProdW'(s1_ax_q) * ProdW'(alpha_recip_q);
    u_round    = (SumW'(recip_prod) + (SumW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    u_clamp    = (u_round > (SumW'(1) << (UW - 1))) ? (SumW'(1) << (UW - 1)) : u_round;
  end

  always_comb begin
    alpha_prod = (CW+NW+1)'(alpha_scale_q) * (CW+NW+1)'(lut_m)
               + ((CW+NW+1)'(1) << (TQ - 1));
  end

  always_comb begin
    mag_ext    = CmpW'(s5_mag_q);
    mag_sat    = (mag_ext > (CmpW'(1) << (W - 1))) ? (CmpW'(1) << (W - 1)) : mag_ext;
    neg_res    = ~mag_sat[W-1:0] + W'(1);
    out_data_d = s5_pos_q ? s5_x_q : neg_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s5_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= start_i;
      s2_valid_q  <= s1_valid_q;
      s5_valid_q  <= lut_valid;
      out_valid_q <= s5_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_x_q     <= sample_i;
    s1_pos_q   <= (sample_i != '0) && !sample_i[W-1];
    s1_ax_q    <= ~sample_i + W'(1);
    s2_x_q     <= s1_x_q;
    s2_pos_q   <= s1_pos_q;
    s2_u_q     <= u_clamp[UW-1:0];
    s3_x_q     <= s2_x_q;
    s3_pos_q   <= s2_pos_q;
    s4_x_q     <= s3_x_q;
    s4_pos_q   <= s3_pos_q;
    s5_x_q     <= s4_x_q;
    s5_pos_q   <= s4_pos_q;
    s5_mag_q   <= alpha_prod[CW+NW:TQ];
    out_data_q <= out_data_d;
  end

  celu_expm1_interp #(
    .FRAC_BITS         (FRAC_BITS),
    .EXP_TABLE_ENTRIES (EXP_TABLE_ENTRIES)
  ) u_expm1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid_q),
    .u_i     (s2_u_q),
    .valid_o (lut_valid),
    .m_o     (lut_m)
  );

  assign valid_o     = out_valid_q;
  assign activated_o = out_data_q;

endmodule
